/* rtl/pid_term_calculator_top_assert.svh */
// Assertion macros for the PID term calculator.
`ifndef PID_TERM_CALCULATOR_TOP_ASSERT_SVH
`define PID_TERM_CALCULATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ptc_pkg.sv */
// Package for the PID term calculator: widths, register indexes, saturation.
package ptc_pkg;

    localparam int unsigned ErrWidth   = 17;
    localparam int unsigned DiffWidth  = 18;
    localparam int unsigned SumWidth   = 32;
    localparam int unsigned GainWidth  = 16;
    localparam int unsigned TermWidth  = 32;
    localparam int unsigned ShiftWidth = 40;
    localparam int unsigned CfgAddrWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    localparam logic [CfgAddrWidth-1:0] REG_TARGET      = 3'd0;
    localparam logic [CfgAddrWidth-1:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [CfgAddrWidth-1:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [CfgAddrWidth-1:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [CfgAddrWidth-1:0] REG_ACCUM_LIMIT = 3'd4;

    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    localparam logic signed [TermWidth-1:0] TERM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TermWidth-1:0] TERM_MIN = 32'sh8000_0000;

    // Clip a shifted product to the signed 32-bit range.
    function automatic logic signed [TermWidth-1:0] sat_term(
        input logic signed [ShiftWidth-1:0] v
    );
        logic hi_ok;
        hi_ok = (v[ShiftWidth-1:TermWidth-1] == '0) || (v[ShiftWidth-1:TermWidth-1] == '1);
        if (hi_ok)
            return v[TermWidth-1:0];
        else if (v[ShiftWidth-1])
            return TERM_MIN;
        else
            return TERM_MAX;
    endfunction

endpackage

/* rtl/pid_term_calculator_top.sv */
// PID term calculator: error update, integral clamp and Q8.8 gain products.
//
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_axis_tvalid/tready    | tuser kind, tdata reading, reset_error
//  m_axis    | out | m_axis_tvalid/tready    | tdata p_term, i_term, d_term
//  cfg       | in  | cfg_we                  | cfg_addr index, cfg_wdata value
//
// One word accepted per cycle while s_axis_tready is high; each word gives one result word.
// Stages: error/total update, integral clamp, gain multiplies, shift and saturate.
// The error stores update at input accept, so words in flight never wait on each other.
// A stall on m_axis backs up the stages in order; s_axis_tready drops only when all are full.
// rst_n clears error stores, valid flags, target and gains at once; accum limit goes to -1.
module pid_term_calculator_top
    import ptc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [39:0]             s_axis_tdata,   // [15:0] reading, [32:16] reset_error
    input  logic                    s_axis_tuser,   // [0] kind
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [95:0]             m_axis_tdata,   // [31:0] p_term, [63:32] i_term,
                                                    // [95:64] d_term
    input  logic                    cfg_we,
    input  logic [CfgAddrWidth-1:0] cfg_addr,
    input  logic [CfgDataWidth-1:0] cfg_wdata
);

    // Configuration registers
    logic signed [GainWidth-1:0] target_reg;
    logic signed [GainWidth-1:0] prop_gain_reg;
    logic signed [GainWidth-1:0] integ_gain_reg;
    logic signed [GainWidth-1:0] deriv_gain_reg;
    logic signed [SumWidth-1:0]  accum_limit_reg;

    // Error state
    logic signed [ErrWidth-1:0] err_now_reg;
    logic signed [ErrWidth-1:0] err_before_reg;
    logic signed [SumWidth-1:0] err_sum_reg;
    logic signed [ErrWidth-1:0] err_now_next;
    logic signed [ErrWidth-1:0] err_before_next;
    logic signed [SumWidth-1:0] err_sum_next;

    // Pipeline stages
    logic                        v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic signed [ErrWidth-1:0]  s1_err_reg, s2_err_reg;
    logic signed [DiffWidth-1:0] s1_diff_reg, s2_diff_reg;
    logic signed [SumWidth-1:0]  s1_sum_reg, s2_total_reg;
    logic signed [32:0]          p_prod_reg;
    logic signed [47:0]          i_prod_reg;
    logic signed [33:0]          d_prod_reg;
    logic [95:0]                 out_data_reg;

    logic in_fire;
    logic adv_out, adv3, adv2, adv1;

    logic signed [GainWidth-1:0] reading;
    logic signed [ErrWidth-1:0]  load_val;
    logic                        kind;
    logic signed [SumWidth:0]    sum_wide;
    logic signed [SumWidth-1:0]  neg_limit;
    logic signed [SumWidth-1:0]  total_next;
    logic signed [24:0]          p_sh;
    logic signed [25:0]          d_sh;
    logic signed [TermWidth-1:0] p_term, i_term, d_term;

    assign kind     = s_axis_tuser;
    assign reading  = s_axis_tdata[15:0];
    assign load_val = s_axis_tdata[32:16];

    // Backpressure chain from the output register toward the input
    assign adv_out = !out_valid_reg || m_axis_tready;
    assign adv3    = !v3_reg || adv_out;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_axis_tready = adv1;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Error update
    always_comb
    begin
        sum_wide = '0;
        if (kind == KIND_LOAD)
        begin
            err_now_next    = load_val;
            err_before_next = load_val;
            err_sum_next    = {{(SumWidth-ErrWidth){load_val[ErrWidth-1]}}, load_val};
        end
        else
        begin
            err_before_next = err_now_reg;
            err_now_next    = {target_reg[GainWidth-1], target_reg}
                            - {reading[GainWidth-1], reading};
            sum_wide        = {err_sum_reg[SumWidth-1], err_sum_reg}
                            + {{(SumWidth+1-ErrWidth){err_now_next[ErrWidth-1]}}, err_now_next};
            if (sum_wide[SumWidth] != sum_wide[SumWidth-1])
                err_sum_next = sum_wide[SumWidth] ? TERM_MIN : TERM_MAX;
            else
                err_sum_next = sum_wide[SumWidth-1:0];
        end
    end

    // Integral clamp; a negative limit passes the total through
    assign neg_limit = -accum_limit_reg;
    always_comb
    begin
        total_next = s1_sum_reg;
        if (!accum_limit_reg[SumWidth-1])
        begin
            if (s1_sum_reg > accum_limit_reg)
                total_next = accum_limit_reg;
            else if (s1_sum_reg < neg_limit)
                total_next = neg_limit;
        end
    end

    // Floor shift by 8 is an arithmetic drop of the low byte
    assign p_sh   = p_prod_reg[32:8];
    assign d_sh   = d_prod_reg[33:8];
    assign p_term = sat_term({{15{p_sh[24]}}, p_sh});
    assign i_term = sat_term(i_prod_reg[47:8]);
    assign d_term = sat_term({{14{d_sh[25]}}, d_sh});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            accum_limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET:      target_reg      <= cfg_wdata[GainWidth-1:0];
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GainWidth-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GainWidth-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[GainWidth-1:0];
                REG_ACCUM_LIMIT: accum_limit_reg <= cfg_wdata[SumWidth-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_now_reg    <= '0;
            err_before_reg <= '0;
            err_sum_reg    <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                err_now_reg    <= err_now_next;
                err_before_reg <= err_before_next;
                err_sum_reg    <= err_sum_next;
            end
            if (adv1)
                v1_reg <= in_fire;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv_out)
                out_valid_reg <= v3_reg;
        end
    end

    // Payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (adv1 && in_fire)
        begin
            s1_err_reg  <= err_now_next;
            s1_diff_reg <= {err_now_next[ErrWidth-1], err_now_next}
                         - {err_before_next[ErrWidth-1], err_before_next};
            s1_sum_reg  <= err_sum_next;
        end
        if (adv2 && v1_reg)
        begin
            s2_err_reg   <= s1_err_reg;
            s2_diff_reg  <= s1_diff_reg;
            s2_total_reg <= total_next;
        end
        if (adv3 && v2_reg)
        begin
            p_prod_reg <= 33'(prop_gain_reg) * 33'(s2_err_reg);
            i_prod_reg <= 48'(integ_gain_reg) * 48'(s2_total_reg);
            d_prod_reg <= 34'(deriv_gain_reg) * 34'(s2_diff_reg);
        end
        if (adv_out && v3_reg)
            out_data_reg <= {d_term, i_term, p_term};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`include "pid_term_calculator_top_assert.svh"

    `PTC_ASSERT_NEXT(a_load_fills_all, in_fire && kind == KIND_LOAD,
        err_now_reg == err_before_reg && err_sum_reg[ErrWidth-1:0] == err_now_reg,
        "error load did not reach all stores")
    `PTC_ASSERT_NEXT(a_reading_shifts, in_fire && kind == KIND_READING,
        err_before_reg == $past(err_now_reg), "previous error not taken from current")
    `PTC_ASSERT_NOW(a_clamp_bound, v2_reg && !accum_limit_reg[SumWidth-1],
        s2_total_reg <= accum_limit_reg && s2_total_reg >= neg_limit,
        "clamped total outside limit")
    `PTC_ASSERT_NEXT(a_stall_holds_stage, v3_reg && !adv_out,
        v3_reg && $stable(p_prod_reg), "product stage lost during stall")

endmodule
